// ----- rtl/qots_pkg.sv -----
// shared types and codes for the quadratic outline decomposer
`default_nettype none

package qots_pkg;

  // point kind codes on the input; the unused codes 2 and 3 are treated as cubic
  localparam logic [1:0] KIND_ON    = 2'd0;
  localparam logic [1:0] KIND_CONIC = 2'd1;

  // result status
  typedef enum logic [1:0] {
    ST_SEGMENT   = 2'd0,
    ST_OFF_START = 2'd1,
    ST_CUBIC     = 2'd2
  } status_e;

  // slot of each coordinate within a packed result
  localparam int C_SX = 0;
  localparam int C_SY = 1;
  localparam int C_CX = 2;
  localparam int C_CY = 3;
  localparam int C_EX = 4;
  localparam int C_EY = 5;
  localparam int NumCoords = 6;

  typedef struct packed {
    status_e status;
    logic    closes;
    logic    last;
  } res_flags_t;

  // contour walker control state
  typedef struct packed {
    logic prev_conic;
    logic at_start;
    logic dropping;
  } walk_flags_t;

endpackage

`default_nettype wire

// ----- rtl/qots_step.sv -----
// per-point decode: next walker state and up to two segments
`default_nettype none

module qots_step #(
  parameter int CoordW = 24
) (
  input  logic [CoordW-1:0]                         pt_x_i,
  input  logic [CoordW-1:0]                         pt_y_i,
  input  logic [1:0]                                kind_i,
  input  logic                                      end_i,
  input  qots_pkg::walk_flags_t                     flags_i,
  input  logic [CoordW-1:0]                         first_x_i,
  input  logic [CoordW-1:0]                         first_y_i,
  input  logic [CoordW-1:0]                         prev_x_i,
  input  logic [CoordW-1:0]                         prev_y_i,
  input  logic [CoordW-1:0]                         cs_x_i,
  input  logic [CoordW-1:0]                         cs_y_i,
  output qots_pkg::walk_flags_t                     flags_o,
  output logic [CoordW-1:0]                         first_x_o,
  output logic [CoordW-1:0]                         first_y_o,
  output logic [CoordW-1:0]                         prev_x_o,
  output logic [CoordW-1:0]                         prev_y_o,
  output logic [CoordW-1:0]                         cs_x_o,
  output logic [CoordW-1:0]                         cs_y_o,
  output logic [1:0]                                res_valid_o,
  output logic [qots_pkg::NumCoords-1:0][CoordW:0]  res0_o,
  output logic [qots_pkg::NumCoords-1:0][CoordW:0]  res1_o,
  output qots_pkg::res_flags_t                      flg0_o,
  output qots_pkg::res_flags_t                      flg1_o
);
  import qots_pkg::*;

  localparam int OutW = CoordW + 1;
  typedef logic [NumCoords-1:0][OutW-1:0] coords_t;

  // doubled point, exact 1/128 pixel value
  function automatic logic [OutW-1:0] dbl(input logic [CoordW-1:0] a);
    return {a, 1'b0};
  endfunction

  function automatic logic [OutW-1:0] sum2(input logic [CoordW-1:0] a,
                                           input logic [CoordW-1:0] b);
    return {a[CoordW-1], a} + {b[CoordW-1], b};
  endfunction

  function automatic coords_t mk_line(input logic [CoordW-1:0] ax,
                                      input logic [CoordW-1:0] ay,
                                      input logic [CoordW-1:0] bx,
                                      input logic [CoordW-1:0] by);
    coords_t c;
    c[C_SX] = dbl(ax);
    c[C_SY] = dbl(ay);
    c[C_CX] = sum2(ax, bx);
    c[C_CY] = sum2(ay, by);
    c[C_EX] = dbl(bx);
    c[C_EY] = dbl(by);
    return c;
  endfunction

  function automatic coords_t mk_curve(input logic [CoordW-1:0] ax,
                                       input logic [CoordW-1:0] ay,
                                       input logic [CoordW-1:0] qx,
                                       input logic [CoordW-1:0] qy,
                                       input logic [CoordW-1:0] bx,
                                       input logic [CoordW-1:0] by);
    coords_t c;
    c[C_SX] = dbl(ax);
    c[C_SY] = dbl(ay);
    c[C_CX] = dbl(qx);
    c[C_CY] = dbl(qy);
    c[C_EX] = dbl(bx);
    c[C_EY] = dbl(by);
    return c;
  endfunction

  logic [OutW-1:0]   sum_x, sum_y;
  logic [CoordW-1:0] mid_x, mid_y;

  // implied on-curve point, floor of the half sum
  assign sum_x = sum2(prev_x_i, pt_x_i);
  assign sum_y = sum2(prev_y_i, pt_y_i);
  assign mid_x = sum_x[OutW-1:1];
  assign mid_y = sum_y[OutW-1:1];

  always_comb begin
    flags_o     = flags_i;
    first_x_o   = first_x_i;
    first_y_o   = first_y_i;
    prev_x_o    = prev_x_i;
    prev_y_o    = prev_y_i;
    cs_x_o      = cs_x_i;
    cs_y_o      = cs_y_i;
    res_valid_o = 2'b00;
    res0_o      = '0;
    res1_o      = '0;
    flg0_o      = '{status: ST_SEGMENT, closes: 1'b0, last: 1'b0};
    flg1_o      = '{status: ST_SEGMENT, closes: 1'b0, last: 1'b1};

    if (flags_i.dropping) begin
      if (end_i) begin
        flags_o.dropping = 1'b0;
        flags_o.at_start = 1'b1;
      end
    end else if (flags_i.at_start) begin
      if (kind_i != KIND_ON) begin
        res_valid_o    = 2'b01;
        flg0_o.status  = ST_OFF_START;
        flg0_o.closes  = 1'b1;
        flags_o.dropping = !end_i;
      end else begin
        first_x_o          = pt_x_i;
        first_y_o          = pt_y_i;
        prev_x_o           = pt_x_i;
        prev_y_o           = pt_y_i;
        cs_x_o             = pt_x_i;
        cs_y_o             = pt_y_i;
        flags_o.prev_conic = 1'b0;
        flags_o.at_start   = 1'b0;
        if (end_i) begin
          // single-point contour closes onto itself
          res_valid_o      = 2'b01;
          res0_o           = mk_line(pt_x_i, pt_y_i, pt_x_i, pt_y_i);
          flg0_o.closes    = 1'b1;
          flags_o.at_start = 1'b1;
        end
      end
    end else begin
      case (kind_i)
        KIND_ON: begin
          res_valid_o[0] = 1'b1;
          if (flags_i.prev_conic) begin
            res0_o = mk_curve(cs_x_i, cs_y_i, prev_x_i, prev_y_i, pt_x_i, pt_y_i);
          end else begin
            res0_o = mk_line(prev_x_i, prev_y_i, pt_x_i, pt_y_i);
          end
          prev_x_o           = pt_x_i;
          prev_y_o           = pt_y_i;
          flags_o.prev_conic = 1'b0;
          if (end_i) begin
            res_valid_o[1]   = 1'b1;
            res1_o           = mk_line(pt_x_i, pt_y_i, first_x_i, first_y_i);
            flg1_o.closes    = 1'b1;
            flags_o.at_start = 1'b1;
          end
        end
        KIND_CONIC: begin
          if (flags_i.prev_conic) begin
            res_valid_o[0] = 1'b1;
            res0_o = mk_curve(cs_x_i, cs_y_i, prev_x_i, prev_y_i, mid_x, mid_y);
            cs_x_o = mid_x;
            cs_y_o = mid_y;
            if (end_i) begin
              res_valid_o[1] = 1'b1;
              res1_o = mk_curve(mid_x, mid_y, pt_x_i, pt_y_i, first_x_i, first_y_i);
              flg1_o.closes = 1'b1;
            end
          end else begin
            cs_x_o = prev_x_i;
            cs_y_o = prev_y_i;
            if (end_i) begin
              res_valid_o[0] = 1'b1;
              res0_o = mk_curve(prev_x_i, prev_y_i, pt_x_i, pt_y_i,
                                first_x_i, first_y_i);
              flg0_o.closes = 1'b1;
            end
          end
          prev_x_o           = pt_x_i;
          prev_y_o           = pt_y_i;
          flags_o.prev_conic = 1'b1;
          if (end_i) begin
            flags_o.at_start = 1'b1;
          end
        end
        default: begin
          // cubic control points are not supported
          res_valid_o      = 2'b01;
          flg0_o.status    = ST_CUBIC;
          flg0_o.closes    = 1'b1;
          flags_o.at_start = 1'b1;
          flags_o.dropping = !end_i;
        end
      endcase
    end

    flg0_o.last = !res_valid_o[1];
  end

endmodule

`default_nettype wire

// ----- rtl/qots_out_buf.sv -----
// two-entry result buffer, takes one or two results per cycle while it has room for them
`default_nettype none

module qots_out_buf #(
  parameter int OutW = 25
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [1:0]                              push_i,
  input  logic [qots_pkg::NumCoords-1:0][OutW-1:0] data0_i,
  input  logic [qots_pkg::NumCoords-1:0][OutW-1:0] data1_i,
  input  qots_pkg::res_flags_t                    flg0_i,
  input  qots_pkg::res_flags_t                    flg1_i,
  output logic [1:0]                              free_o,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [qots_pkg::NumCoords-1:0][OutW-1:0] data_o,
  output qots_pkg::res_flags_t                    flg_o
);
  import qots_pkg::*;

  logic [NumCoords-1:0][OutW-1:0] mem_q [2];
  res_flags_t                     flg_q [2];
  logic [1:0] count_q, count_d, npush;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  assign flg_o   = flg_q[rd_q];
  // space left after this cycle's transfer out
  assign free_o  = 2'd2 - count_q + {1'b0, pop};

  // push_i[1] only ever comes with push_i[0]
  assign npush   = {1'b0, push_i[0]} + {1'b0, push_i[1]};
  assign count_d = count_q + npush - {1'b0, pop};
  assign wr_d    = wr_q ^ npush[0];
  assign rd_d    = rd_q ^ pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= data0_i;
      flg_q[wr_q] <= flg0_i;
    end
    if (push_i[1]) begin
      mem_q[~wr_q] <= data1_i;
      flg_q[~wr_q] <= flg1_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/quadratic_outline_to_segments.sv -----
// top level: glyph outline points in, quadratic segments out
//
//   channel  handshake               payload
//   point    in_valid_i/in_ready_o   point_x_i point_y_i point_kind_i contour_end_i
//   segment  out_valid_o/out_ready_i start/ctrl/end x,y  status closes last_of_run
//
// one point per cycle; a point that yields two segments (contour end) needs two
// output transfers, and the input stalls only while the buffer lacks room for
// all of a point's segments.
// path: point register, decode, then the two-entry result buffer, so a
// segment is visible only after both the point register and the buffer.
// reset returns the walker to a contour start and empties both stages.
// output stall backs up through the buffer into the point register.
`default_nettype none

module quadratic_outline_to_segments #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [1:0]            point_kind_i,
  input  logic                  contour_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS:0]   start_x_o,
  output logic [COORD_BITS:0]   start_y_o,
  output logic [COORD_BITS:0]   ctrl_x_o,
  output logic [COORD_BITS:0]   ctrl_y_o,
  output logic [COORD_BITS:0]   end_x_o,
  output logic [COORD_BITS:0]   end_y_o,
  output logic [1:0]            status_o,
  output logic                  closes_contour_o,
  output logic                  last_of_run_o
);
  import qots_pkg::*;

  localparam int OutW = COORD_BITS + 1;

  // point register
  logic                  pv_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [1:0]            pk_q;
  logic                  pe_q;

  // walker state
  walk_flags_t           flags_q, flags_d;
  logic [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cs_x_q, cs_y_q;
  logic [COORD_BITS-1:0] first_x_d, first_y_d, prev_x_d, prev_y_d, cs_x_d, cs_y_d;

  logic [1:0]                    res_valid, free, need, push;
  logic [NumCoords-1:0][OutW-1:0] res0, res1, res_out;
  res_flags_t                    flg0, flg1, flg_out;
  logic                          fire;

  qots_step #(.CoordW(COORD_BITS)) u_step (
    .pt_x_i      (px_q),
    .pt_y_i      (py_q),
    .kind_i      (pk_q),
    .end_i       (pe_q),
    .flags_i     (flags_q),
    .first_x_i   (first_x_q),
    .first_y_i   (first_y_q),
    .prev_x_i    (prev_x_q),
    .prev_y_i    (prev_y_q),
    .cs_x_i      (cs_x_q),
    .cs_y_i      (cs_y_q),
    .flags_o     (flags_d),
    .first_x_o   (first_x_d),
    .first_y_o   (first_y_d),
    .prev_x_o    (prev_x_d),
    .prev_y_o    (prev_y_d),
    .cs_x_o      (cs_x_d),
    .cs_y_o      (cs_y_d),
    .res_valid_o (res_valid),
    .res0_o      (res0),
    .res1_o      (res1),
    .flg0_o      (flg0),
    .flg1_o      (flg1)
  );

  // the held point retires once the buffer has room for all its results
  assign need       = {1'b0, res_valid[0]} + {1'b0, res_valid[1]};
  assign fire       = pv_q && (need <= free);
  assign push       = fire ? res_valid : 2'b00;
  assign in_ready_o = !pv_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      flags_q <= '{prev_conic: 1'b0, at_start: 1'b1, dropping: 1'b0};
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cs_x_q    <= '0;
      cs_y_q    <= '0;
    end else begin
      if (in_ready_o) begin
        pv_q <= in_valid_i;
      end
      if (fire) begin
        flags_q   <= flags_d;
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        prev_x_q  <= prev_x_d;
        prev_y_q  <= prev_y_d;
        cs_x_q    <= cs_x_d;
        cs_y_q    <= cs_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pk_q <= point_kind_i;
      pe_q <= contour_end_i;
    end
  end

  qots_out_buf #(.OutW(OutW)) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (res0),
    .data1_i (res1),
    .flg0_i  (flg0),
    .flg1_i  (flg1),
    .free_o  (free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out),
    .flg_o   (flg_out)
  );

  assign start_x_o        = res_out[C_SX];
  assign start_y_o        = res_out[C_SY];
  assign ctrl_x_o         = res_out[C_CX];
  assign ctrl_y_o         = res_out[C_CY];
  assign end_x_o          = res_out[C_EX];
  assign end_y_o          = res_out[C_EY];
  assign status_o         = flg_out.status;
  assign closes_contour_o = flg_out.closes;
  assign last_of_run_o    = flg_out.last;

endmodule

`default_nettype wire
